// ----- rtl/lru_cache_with_age_expiry_assert.svh -----
// assertion macros for the lru cache
`ifndef LRU_CACHE_WITH_AGE_EXPIRY_ASSERT_SVH
`define LRU_CACHE_WITH_AGE_EXPIRY_ASSERT_SVH

// same-cycle implication
`define LRUC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru cache assertion failed");

// next-cycle implication
`define LRUC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru cache assertion failed");

`endif

// ----- rtl/lruc_pkg.sv -----
`default_nettype none

package lruc_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SLOT_W   = 4;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int NOW_W    = 48;
  localparam int STAMP_W  = 64;
  localparam int ACT_W    = 5;
  localparam int MAXAGE_W = 32;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(16);

  localparam logic REG_ACTIVE_ENTRIES = 1'b0;
  localparam logic REG_MAX_AGE        = 1'b1;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT          = 3'd0,
    ST_MISS         = 3'd1,
    ST_EXPIRED      = 3'd2,
    ST_STORED_FREE  = 3'd3,
    ST_HELD         = 3'd4,
    ST_STORED_EVICT = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [NOW_W-1:0]   inserted;
    logic [STAMP_W-1:0] last_use;
  } entry_t;

  typedef struct packed {
    logic [ACT_W-1:0]    active_entries;
    logic [MAXAGE_W-1:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/lruc_cfg.sv -----
`default_nettype none

module lruc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lruc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lruc_pkg::DATA_W-1:0] pwdata,
  output logic      [lruc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lruc_pkg::cfg_t                  cfg
);

  lruc_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_entries <= lruc_pkg::ACTIVE_RESET;
      cfg_r.max_age        <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        lruc_pkg::REG_ACTIVE_ENTRIES: begin
          cfg_r.active_entries <= pwdata[lruc_pkg::ACT_W-1:0];
        end
        lruc_pkg::REG_MAX_AGE: begin
          cfg_r.max_age <= pwdata[lruc_pkg::MAXAGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lruc_pkg::REG_ACTIVE_ENTRIES: begin
        prdata = lruc_pkg::DATA_W'(cfg_r.active_entries);
      end
      lruc_pkg::REG_MAX_AGE: begin
        prdata = lruc_pkg::DATA_W'(cfg_r.max_age);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/lruc_mem.sv -----
`default_nettype none

module lruc_mem (
  input  wire logic               clk,
  input  wire lruc_pkg::mem_req_t req,
  output lruc_pkg::entry_t        rdata
);

  lruc_pkg::entry_t mem [lruc_pkg::ENTRIES];
  lruc_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/lruc_ctrl.sv -----
`default_nettype none

module lruc_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_mode,
  input  wire logic [lruc_pkg::KEY_W-1:0]   in_key,
  input  wire logic [lruc_pkg::VALUE_W-1:0] in_value,
  input  wire logic [lruc_pkg::NOW_W-1:0]   in_now,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lruc_pkg::STATUS_W-1:0]     out_status,
  output logic [lruc_pkg::VALUE_W-1:0]      out_hit_value,
  output logic [lruc_pkg::SLOT_W-1:0]       out_slot,
  input  wire lruc_pkg::cfg_t               cfg,
  output lruc_pkg::mem_req_t                mem_req,
  input  wire lruc_pkg::entry_t             mem_rdata
);

  lruc_pkg::state_t state_r, state_nxt;

  // request
  logic                           mode_r;
  logic [lruc_pkg::KEY_W-1:0]     key_r;
  logic [lruc_pkg::VALUE_W-1:0]   value_r;
  logic [lruc_pkg::NOW_W-1:0]     now_r;
  logic [lruc_pkg::CNT_W-1:0]     span_r, span_nxt;

  // scan
  logic [lruc_pkg::CNT_W-1:0]     cnt_r;
  logic                           cmp_vld_r;
  logic [lruc_pkg::IDX_W-1:0]     cmp_idx_r;
  logic                           found_r;
  logic [lruc_pkg::IDX_W-1:0]     match_idx_r;
  lruc_pkg::entry_t               match_ent_r;
  logic                           free_r;
  logic [lruc_pkg::IDX_W-1:0]     free_idx_r;
  logic                           have_min_r;
  logic [lruc_pkg::STAMP_W-1:0]   min_r;
  logic [lruc_pkg::IDX_W-1:0]     min_idx_r;
  logic                           expired_r;

  // state kept across transactions
  logic [lruc_pkg::ENTRIES-1:0]   valid_r;
  logic [lruc_pkg::STAMP_W-1:0]   access_clock_r;

  // result register
  logic                           out_valid_r;
  lruc_pkg::status_t              out_status_r;
  logic [lruc_pkg::VALUE_W-1:0]   out_hit_value_r;
  logic [lruc_pkg::SLOT_W-1:0]    out_slot_r;

  logic                           scan_issue;
  logic                           finish_go;
  logic [lruc_pkg::IDX_W-1:0]     pick_idx;
  logic [lruc_pkg::STAMP_W-1:0]   stamp;
  logic                           bump_clock;
  logic                           set_valid;
  logic                           clr_valid;
  lruc_pkg::status_t              res_status;
  logic [lruc_pkg::VALUE_W-1:0]   res_value;
  logic [lruc_pkg::IDX_W-1:0]     res_idx;
  logic                           cur_valid;
  logic [lruc_pkg::NOW_W-1:0]     age;

  always_comb begin
    if (cfg.active_entries == '0) begin
      span_nxt = lruc_pkg::CNT_W'(1);
    end else if (int'(cfg.active_entries) > lruc_pkg::ENTRIES) begin
      span_nxt = lruc_pkg::CNT_W'(lruc_pkg::ENTRIES);
    end else begin
      span_nxt = lruc_pkg::CNT_W'(cfg.active_entries);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lruc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    finish_go  = 1'b0;
    scan_issue = (state_r == lruc_pkg::S_SCAN) && (cnt_r < span_r);
    case (state_r)
      lruc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = lruc_pkg::S_SCAN;
        end
      end
      lruc_pkg::S_SCAN: begin
        if (!scan_issue && !cmp_vld_r) begin
          state_nxt = lruc_pkg::S_DECIDE;
        end
      end
      lruc_pkg::S_DECIDE: begin
        state_nxt = lruc_pkg::S_FINISH;
      end
      lruc_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          finish_go = 1'b1;
          state_nxt = lruc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lruc_pkg::S_IDLE;
      end
    endcase

    pick_idx   = free_r ? free_idx_r : min_idx_r;
    stamp      = access_clock_r + 1'b1;
    bump_clock = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    res_value  = '0;
    res_idx    = '0;
    res_status = lruc_pkg::ST_MISS;

    mem_req.we             = 1'b0;
    mem_req.waddr          = pick_idx;
    mem_req.wdata.key      = key_r;
    mem_req.wdata.value    = value_r;
    mem_req.wdata.inserted = now_r;
    mem_req.wdata.last_use = stamp;
    mem_req.raddr          = cnt_r[lruc_pkg::IDX_W-1:0];

    if (mode_r == lruc_pkg::MODE_LOOKUP) begin
      if (!found_r) begin
        res_status = lruc_pkg::ST_MISS;
      end else if (expired_r) begin
        res_status = lruc_pkg::ST_EXPIRED;
        res_idx    = match_idx_r;
        clr_valid  = 1'b1;
      end else begin
        res_status             = lruc_pkg::ST_HIT;
        res_idx                = match_idx_r;
        res_value              = match_ent_r.value;
        bump_clock             = 1'b1;
        mem_req.we             = 1'b1;
        mem_req.waddr          = match_idx_r;
        mem_req.wdata          = match_ent_r;
        mem_req.wdata.last_use = stamp;
      end
    end else begin
      if (found_r) begin
        res_status = lruc_pkg::ST_HELD;
        res_idx    = match_idx_r;
      end else begin
        res_status = free_r ? lruc_pkg::ST_STORED_FREE : lruc_pkg::ST_STORED_EVICT;
        res_idx    = pick_idx;
        bump_clock = 1'b1;
        set_valid  = 1'b1;
        mem_req.we = 1'b1;
      end
    end

    mem_req.we = mem_req.we && finish_go;
  end

  assign cur_valid = valid_r[cmp_idx_r];
  assign age = (now_r >= match_ent_r.inserted) ? (now_r - match_ent_r.inserted) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= '0;
      access_clock_r <= '0;
      out_valid_r    <= 1'b0;
      cmp_vld_r      <= 1'b0;
    end else begin
      cmp_vld_r <= scan_issue;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish_go) begin
        out_valid_r <= 1'b1;
        if (set_valid) begin
          valid_r[pick_idx] <= 1'b1;
        end
        if (clr_valid) begin
          valid_r[match_idx_r] <= 1'b0;
        end
        if (bump_clock) begin
          access_clock_r <= stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r     <= in_mode;
      key_r      <= in_key;
      value_r    <= in_value;
      now_r      <= in_now;
      span_r     <= span_nxt;
      cnt_r      <= '0;
      found_r    <= 1'b0;
      free_r     <= 1'b0;
      have_min_r <= 1'b0;
    end
    if (scan_issue) begin
      cnt_r     <= cnt_r + 1'b1;
      cmp_idx_r <= cnt_r[lruc_pkg::IDX_W-1:0];
    end
    if (cmp_vld_r) begin
      if (cur_valid && (mem_rdata.key == key_r) && !found_r) begin
        found_r     <= 1'b1;
        match_idx_r <= cmp_idx_r;
        match_ent_r <= mem_rdata;
      end
      if (!cur_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
      if (cur_valid && (!have_min_r || (mem_rdata.last_use < min_r))) begin
        have_min_r <= 1'b1;
        min_r      <= mem_rdata.last_use;
        min_idx_r  <= cmp_idx_r;
      end
    end
    if (state_r == lruc_pkg::S_DECIDE) begin
      expired_r <= (cfg.max_age != '0) && (age > lruc_pkg::NOW_W'(cfg.max_age));
    end
    if (finish_go) begin
      out_status_r    <= res_status;
      out_hit_value_r <= res_value;
      out_slot_r      <= lruc_pkg::SLOT_W'(res_idx);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit_value = out_hit_value_r;
  assign out_slot      = out_slot_r;

endmodule

`default_nettype wire

// ----- rtl/lru_cache_with_age_expiry.sv -----
// lru_cache_with_age_expiry: fully associative key-to-value cache with
// least-recently-used replacement and optional age expiry.
// Input channel (in_valid/in_ready): one transaction is a lookup (in_mode 0)
// or an insert (in_mode 1) with in_key, in_value and the time in_now.
// Output channel (out_valid/out_ready): exactly one result per transaction,
// giving out_status, out_hit_value and out_slot.
// Configuration through the APB port: active_entries at address 0 and
// max_age at address 4; write only while no transaction is in flight.
// After acceptance the block scans span slots, span being active_entries
// clamped to 1..16, then passes the decide and finish states. One slot is
// read from the entry memory per cycle during the scan, so that read port
// sets the rate; in_ready is high only in idle, one transaction at a time.
// A finished result sits in the output register; the next transaction is
// accepted and scanned meanwhile and waits for the register to drain only
// at its end. A stalled receiver therefore holds the block after one more
// transaction.
// Reset (rst_n, synchronous): all slots free, access clock zero,
// active_entries 16, max_age 0, no result pending.
`default_nettype none

`include "lru_cache_with_age_expiry_assert.svh"

module lru_cache_with_age_expiry (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_mode,
  input  wire logic [lruc_pkg::KEY_W-1:0]   in_key,
  input  wire logic [lruc_pkg::VALUE_W-1:0] in_value,
  input  wire logic [lruc_pkg::NOW_W-1:0]   in_now,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lruc_pkg::STATUS_W-1:0]     out_status,
  output logic [lruc_pkg::VALUE_W-1:0]      out_hit_value,
  output logic [lruc_pkg::SLOT_W-1:0]       out_slot,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lruc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lruc_pkg::DATA_W-1:0]  pwdata,
  output logic      [lruc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  lruc_pkg::cfg_t     cfg;
  lruc_pkg::mem_req_t mem_req;
  lruc_pkg::entry_t   mem_rdata;

  lruc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lruc_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  lruc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .in_value      (in_value),
    .in_now        (in_now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_hit_value (out_hit_value),
    .out_slot      (out_slot),
    .cfg           (cfg),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  `LRUC_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `LRUC_ASSERT_IMP(a_write_when_busy, clk, rst_n, mem_req.we, !in_ready)
  `LRUC_ASSERT_IMP(a_miss_clean, clk, rst_n, out_valid && out_status == lruc_pkg::ST_MISS, out_hit_value == '0 && out_slot == '0)
  `LRUC_ASSERT_IMP(a_expired_no_value, clk, rst_n, out_valid && out_status == lruc_pkg::ST_EXPIRED, out_hit_value == '0)

endmodule

`default_nettype wire
